FILE: src/prsp_pkg.sv
package prsp_pkg;

	// Fixed field widths
	localparam int COORD_W = 16;
	localparam int OFF_W   = 17;
	localparam int SCALE_W = 16;
	localparam int ANGLE_W = 14;
	localparam int CFG_W   = 16;
	localparam int IDX_W   = 3;

	// Fixed-point shape
	localparam int TRIG_SHIFT   = 15;
	localparam int ROTATE_SHIFT = 10;
	localparam int UNITY_SHIFT  = 8;
	localparam int TRIG_DROP    = TRIG_SHIFT - ROTATE_SHIFT;
	localparam int FIX_SHIFT    = ROTATE_SHIFT + UNITY_SHIFT;
	localparam int TRIG_W       = ROTATE_SHIFT + 2;
	localparam int ZOOM_W       = 2 * OFF_W;
	localparam int PROD_W       = TRIG_W + ZOOM_W;
	localparam int SUM_W        = PROD_W + 1;
	localparam int ACC_W        = SUM_W + 1;
	localparam int ROT_W        = TRIG_W + OFF_W + 1;
	localparam int RES_W        = ACC_W - FIX_SHIFT + 1;

	// Angle handling
	localparam int FULL_TURN = 3600;
	localparam int DEG_BIAS  = 720;
	localparam int QUARTER   = 90;

	// Divide-by-ten reciprocals: small one for the angle, wide one for the blend
	localparam logic [15:0] DIV10_ANG_MUL = 16'd52429;
	localparam int          DIV10_ANG_SH  = 19;
	localparam logic [23:0] DIV10_MIX_MUL = 24'd13421773;
	localparam int          DIV10_MIX_SH  = 27;

	// Pipeline stage numbers
	localparam int TRIG_STAGE = 9;
	localparam int OUT_STAGE  = 14;

	typedef enum logic [IDX_W-1:0] {
		CFG_ANGLE   = 3'd0,
		CFG_SCALE_X = 3'd1,
		CFG_SCALE_Y = 3'd2,
		CFG_PIVOT_X = 3'd3,
		CFG_PIVOT_Y = 3'd4,
		CFG_ZOOM    = 3'd5
	} cfg_idx_t;

	typedef struct packed {
		logic signed [ANGLE_W-1:0] angle_tenths;
		logic [SCALE_W-1:0]        scale_x;
		logic [SCALE_W-1:0]        scale_y;
		logic signed [COORD_W-1:0] pivot_x;
		logic signed [COORD_W-1:0] pivot_y;
		logic                      zoom_first;
	} cfg_t;

	// Per-point operands carried alongside the trig pipeline
	typedef struct packed {
		logic signed [OFF_W-1:0]   ox;
		logic signed [OFF_W-1:0]   oy;
		logic signed [COORD_W-1:0] cx;
		logic signed [COORD_W-1:0] cy;
		logic [SCALE_W-1:0]        sx;
		logic [SCALE_W-1:0]        sy;
		logic                      zoom;
	} op_t;

	// round(32767*sin(deg)) for 0..90
	function automatic logic [14:0] quarter_sine(input logic [6:0] a);
		logic [14:0] v;
		unique case (a)
			7'd0: v = 15'd0;      7'd1: v = 15'd572;    7'd2: v = 15'd1144;
			7'd3: v = 15'd1715;   7'd4: v = 15'd2286;   7'd5: v = 15'd2856;
			7'd6: v = 15'd3425;   7'd7: v = 15'd3993;   7'd8: v = 15'd4560;
			7'd9: v = 15'd5126;   7'd10: v = 15'd5690;  7'd11: v = 15'd6252;
			7'd12: v = 15'd6813;  7'd13: v = 15'd7371;  7'd14: v = 15'd7927;
			7'd15: v = 15'd8481;  7'd16: v = 15'd9032;  7'd17: v = 15'd9580;
			7'd18: v = 15'd10126; 7'd19: v = 15'd10668; 7'd20: v = 15'd11207;
			7'd21: v = 15'd11743; 7'd22: v = 15'd12275; 7'd23: v = 15'd12803;
			7'd24: v = 15'd13328; 7'd25: v = 15'd13848; 7'd26: v = 15'd14364;
			7'd27: v = 15'd14876; 7'd28: v = 15'd15383; 7'd29: v = 15'd15886;
			7'd30: v = 15'd16383; 7'd31: v = 15'd16876; 7'd32: v = 15'd17364;
			7'd33: v = 15'd17846; 7'd34: v = 15'd18323; 7'd35: v = 15'd18794;
			7'd36: v = 15'd19260; 7'd37: v = 15'd19720; 7'd38: v = 15'd20173;
			7'd39: v = 15'd20621; 7'd40: v = 15'd21062; 7'd41: v = 15'd21497;
			7'd42: v = 15'd21925; 7'd43: v = 15'd22347; 7'd44: v = 15'd22762;
			7'd45: v = 15'd23170; 7'd46: v = 15'd23571; 7'd47: v = 15'd23964;
			7'd48: v = 15'd24351; 7'd49: v = 15'd24730; 7'd50: v = 15'd25101;
			7'd51: v = 15'd25465; 7'd52: v = 15'd25821; 7'd53: v = 15'd26169;
			7'd54: v = 15'd26509; 7'd55: v = 15'd26841; 7'd56: v = 15'd27165;
			7'd57: v = 15'd27481; 7'd58: v = 15'd27788; 7'd59: v = 15'd28087;
			7'd60: v = 15'd28377; 7'd61: v = 15'd28659; 7'd62: v = 15'd28932;
			7'd63: v = 15'd29196; 7'd64: v = 15'd29451; 7'd65: v = 15'd29697;
			7'd66: v = 15'd29934; 7'd67: v = 15'd30162; 7'd68: v = 15'd30381;
			7'd69: v = 15'd30591; 7'd70: v = 15'd30791; 7'd71: v = 15'd30982;
			7'd72: v = 15'd31163; 7'd73: v = 15'd31335; 7'd74: v = 15'd31498;
			7'd75: v = 15'd31650; 7'd76: v = 15'd31794; 7'd77: v = 15'd31927;
			7'd78: v = 15'd32051; 7'd79: v = 15'd32165; 7'd80: v = 15'd32269;
			7'd81: v = 15'd32364; 7'd82: v = 15'd32448; 7'd83: v = 15'd32523;
			7'd84: v = 15'd32587; 7'd85: v = 15'd32642; 7'd86: v = 15'd32687;
			7'd87: v = 15'd32722; 7'd88: v = 15'd32747; 7'd89: v = 15'd32762;
			7'd90: v = 15'd32767;
			default: v = 15'd0;
		endcase
		return v;
	endfunction

	// Sine of a whole degree in 0..359
	function automatic logic signed [15:0] full_sine(input logic [8:0] deg);
		logic [6:0]  qi;
		logic        neg;
		logic [15:0] mag;
		priority if (deg < 9'd90) begin
			qi  = deg[6:0];
			neg = 1'b0;
		end else if (deg < 9'd180) begin
			qi  = 7'(9'd180 - deg);
			neg = 1'b0;
		end else if (deg < 9'd270) begin
			qi  = 7'(deg - 9'd180);
			neg = 1'b1;
		end else begin
			qi  = 7'(9'd360 - deg);
			neg = 1'b1;
		end
		mag = {1'b0, quarter_sine(qi)};
		return neg ? -$signed(mag) : $signed(mag);
	endfunction

	// n below 4*360
	function automatic logic [8:0] mod360(input logic [10:0] n);
		logic [10:0] r;
		priority if (n >= 11'd1080) r = n - 11'd1080;
		else if (n >= 11'd720)      r = n - 11'd720;
		else if (n >= 11'd360)      r = n - 11'd360;
		else                        r = n;
		return r[8:0];
	endfunction

	function automatic logic signed [COORD_W-1:0] saturate(input logic signed [RES_W-1:0] v);
		logic signed [RES_W-1:0] hi;
		logic signed [RES_W-1:0] lo;
		hi = RES_W'((1 << (COORD_W - 1)) - 1);
		lo = -hi - RES_W'(1);
		priority if (v > hi) return hi[COORD_W-1:0];
		else if (v < lo)     return lo[COORD_W-1:0];
		else                 return v[COORD_W-1:0];
	endfunction

endpackage

FILE: src/prsp_cfg_regs.sv
module prsp_cfg_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [prsp_pkg::IDX_W-1:0]    cfg_index,
	input  logic [prsp_pkg::CFG_W-1:0]    cfg_wdata,
	output prsp_pkg::cfg_t                cfg
);

	prsp_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.angle_tenths <= '0;
			cfg_q.scale_x      <= prsp_pkg::SCALE_W'(1 << prsp_pkg::UNITY_SHIFT);
			cfg_q.scale_y      <= prsp_pkg::SCALE_W'(1 << prsp_pkg::UNITY_SHIFT);
			cfg_q.pivot_x      <= '0;
			cfg_q.pivot_y      <= '0;
			cfg_q.zoom_first   <= 1'b0;
		end else if (cfg_we) begin
			unique case (prsp_pkg::cfg_idx_t'(cfg_index))
				prsp_pkg::CFG_ANGLE:   cfg_q.angle_tenths <=
					$signed(cfg_wdata[prsp_pkg::ANGLE_W-1:0]);
				prsp_pkg::CFG_SCALE_X: cfg_q.scale_x <= cfg_wdata;
				prsp_pkg::CFG_SCALE_Y: cfg_q.scale_y <= cfg_wdata;
				prsp_pkg::CFG_PIVOT_X: cfg_q.pivot_x <= $signed(cfg_wdata);
				prsp_pkg::CFG_PIVOT_Y: cfg_q.pivot_y <= $signed(cfg_wdata);
				prsp_pkg::CFG_ZOOM:    cfg_q.zoom_first <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

FILE: src/prsp_trig.sv
module prsp_trig (
	input  logic                                  clk,
	input  logic signed [prsp_pkg::ANGLE_W-1:0]   lim_s1,
	input  logic                                  zero_s1,
	output logic signed [prsp_pkg::TRIG_W-1:0]    sin_s9,
	output logic signed [prsp_pkg::TRIG_W-1:0]    cos_s9
);

	// index 0: sine, index 1: cosine
	logic [28:0]                       prod_s2;
	logic                              neg_s2;
	logic signed [prsp_pkg::ANGLE_W-1:0] lim_s2, lim_s3;
	logic                              zero_s2, zero_s3, zero_s4, zero_s5;
	logic                              zero_s6, zero_s7, zero_s8;
	logic signed [9:0]                 lo_s3;
	logic signed [4:0]                 rem_s4, rem_s5, rem_s6;
	logic [10:0]                       n_s4   [4];
	logic [8:0]                        deg_s5 [4];
	logic signed [15:0]                tbl_s6 [4];
	logic signed [22:0]                sum_s7 [2];
	logic [45:0]                       prod_s8 [2];
	logic                              neg_s8 [2];

	logic [12:0]        abs_lim;
	logic [8:0]         quo;
	logic signed [13:0] lo_x10;
	logic signed [13:0] rem_full;
	logic signed [11:0] lo12;
	logic signed [5:0]  w_lo;
	logic signed [5:0]  w_hi;
	logic [21:0]        mag [2];
	logic [17:0]        q9  [2];
	logic signed [18:0] sv  [2];
	logic signed [prsp_pkg::TRIG_W-1:0] tr [2];

	localparam logic signed [11:0] OFFS [4] = '{12'sd0, 12'sd1,
		12'(prsp_pkg::QUARTER), 12'(prsp_pkg::QUARTER + 1)};

	// s2: |angle| times reciprocal of ten
	assign abs_lim = lim_s1[prsp_pkg::ANGLE_W-1] ? 13'(-lim_s1) : 13'(lim_s1);

	always_ff @(posedge clk) begin
		prod_s2 <= 29'(abs_lim) * 29'(prsp_pkg::DIV10_ANG_MUL);
		neg_s2  <= lim_s1[prsp_pkg::ANGLE_W-1];
		lim_s2  <= lim_s1;
		zero_s2 <= zero_s1;
	end

	// s3: whole degrees, truncated toward zero
	assign quo = prod_s2[prsp_pkg::DIV10_ANG_SH+8:prsp_pkg::DIV10_ANG_SH];

	always_ff @(posedge clk) begin
		lo_s3   <= neg_s2 ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
		lim_s3  <= lim_s2;
		zero_s3 <= zero_s2;
	end

	// s4: tenths remainder, biased table indexes
	assign lo_x10   = 14'(lo_s3) * 14'sd10;
	assign rem_full = lim_s3 - lo_x10;
	assign lo12     = 12'(lo_s3);

	always_ff @(posedge clk) begin
		rem_s4  <= rem_full[4:0];
		zero_s4 <= zero_s3;
		for (int k = 0; k < 4; k++)
			n_s4[k] <= 11'(lo12 + 12'(prsp_pkg::DEG_BIAS) + OFFS[k]);
	end

	// s5: modulo 360
	always_ff @(posedge clk) begin
		rem_s5  <= rem_s4;
		zero_s5 <= zero_s4;
		for (int k = 0; k < 4; k++)
			deg_s5[k] <= prsp_pkg::mod360(n_s4[k]);
	end

	// s6: table reads
	always_ff @(posedge clk) begin
		rem_s6  <= rem_s5;
		zero_s6 <= zero_s5;
		for (int k = 0; k < 4; k++)
			tbl_s6[k] <= prsp_pkg::full_sine(deg_s5[k]);
	end

	// s7: linear blend between neighboring degrees
	assign w_hi = 6'(rem_s6);
	assign w_lo = 6'sd10 - w_hi;

	always_ff @(posedge clk) begin
		zero_s7 <= zero_s6;
		for (int k = 0; k < 2; k++)
			sum_s7[k] <= 23'(tbl_s6[2*k]) * 23'(w_lo) + 23'(tbl_s6[2*k+1]) * 23'(w_hi);
	end

	// s8: |blend| times reciprocal of ten
	always_comb begin
		for (int k = 0; k < 2; k++)
			mag[k] = sum_s7[k][22] ? 22'(-sum_s7[k]) : 22'(sum_s7[k]);
	end

	always_ff @(posedge clk) begin
		zero_s8 <= zero_s7;
		for (int k = 0; k < 2; k++) begin
			prod_s8[k] <= 46'(mag[k]) * 46'(prsp_pkg::DIV10_MIX_MUL);
			neg_s8[k]  <= sum_s7[k][22];
		end
	end

	// s9: restore sign, drop to rotate precision; zero angle is exact unity
	always_comb begin
		for (int k = 0; k < 2; k++) begin
			q9[k] = prod_s8[k][prsp_pkg::DIV10_MIX_SH+17:prsp_pkg::DIV10_MIX_SH];
			sv[k] = neg_s8[k] ? -$signed({1'b0, q9[k]}) : $signed({1'b0, q9[k]});
			tr[k] = prsp_pkg::TRIG_W'(sv[k] >>> prsp_pkg::TRIG_DROP);
		end
	end

	always_ff @(posedge clk) begin
		sin_s9 <= zero_s8 ? '0 : tr[0];
		cos_s9 <= zero_s8 ? prsp_pkg::TRIG_W'(1 << prsp_pkg::ROTATE_SHIFT) : tr[1];
	end

endmodule

FILE: src/prsp_xform.sv
module prsp_xform (
	input  logic                                  clk,
	input  prsp_pkg::op_t                         op_s1,
	input  logic signed [prsp_pkg::TRIG_W-1:0]    sin_s9,
	input  logic signed [prsp_pkg::TRIG_W-1:0]    cos_s9,
	output logic signed [prsp_pkg::COORD_W-1:0]   out_x_s14,
	output logic signed [prsp_pkg::COORD_W-1:0]   out_y_s14
);

	// operands wait here while the trig pipeline runs
	prsp_pkg::op_t op_s [2:prsp_pkg::TRIG_STAGE];
	prsp_pkg::op_t op_s10, op_s11, op_s12, op_s13;

	logic signed [prsp_pkg::TRIG_W-1:0] sin_s10, cos_s10;
	logic signed [prsp_pkg::ZOOM_W-1:0] zx_s10, zy_s10;
	logic signed [prsp_pkg::PROD_W-1:0] p_s11 [4];
	logic signed [prsp_pkg::SUM_W-1:0]  xs_s12, ys_s12;
	logic signed [prsp_pkg::ACC_W-1:0]  vx_s13, vy_s13;

	logic signed [prsp_pkg::RES_W-1:0]  rx, ry;

	always_ff @(posedge clk) begin
		op_s[2] <= op_s1;
		for (int i = 3; i <= prsp_pkg::TRIG_STAGE; i++)
			op_s[i] <= op_s[i-1];
	end

	// s10: optional pre-scale of offsets
	always_ff @(posedge clk) begin
		op_s10  <= op_s[prsp_pkg::TRIG_STAGE];
		sin_s10 <= sin_s9;
		cos_s10 <= cos_s9;
		if (op_s[prsp_pkg::TRIG_STAGE].zoom) begin
			zx_s10 <= prsp_pkg::ZOOM_W'(op_s[prsp_pkg::TRIG_STAGE].ox) *
				prsp_pkg::ZOOM_W'($signed({1'b0, op_s[prsp_pkg::TRIG_STAGE].sx}));
			zy_s10 <= prsp_pkg::ZOOM_W'(op_s[prsp_pkg::TRIG_STAGE].oy) *
				prsp_pkg::ZOOM_W'($signed({1'b0, op_s[prsp_pkg::TRIG_STAGE].sy}));
		end else begin
			zx_s10 <= prsp_pkg::ZOOM_W'(op_s[prsp_pkg::TRIG_STAGE].ox);
			zy_s10 <= prsp_pkg::ZOOM_W'(op_s[prsp_pkg::TRIG_STAGE].oy);
		end
	end

	// s11: rotation products
	always_ff @(posedge clk) begin
		op_s11   <= op_s10;
		p_s11[0] <= prsp_pkg::PROD_W'(cos_s10) * prsp_pkg::PROD_W'(zx_s10);
		p_s11[1] <= prsp_pkg::PROD_W'(sin_s10) * prsp_pkg::PROD_W'(zy_s10);
		p_s11[2] <= prsp_pkg::PROD_W'(sin_s10) * prsp_pkg::PROD_W'(zx_s10);
		p_s11[3] <= prsp_pkg::PROD_W'(cos_s10) * prsp_pkg::PROD_W'(zy_s10);
	end

	// s12: rotated sums
	always_ff @(posedge clk) begin
		op_s12 <= op_s11;
		xs_s12 <= prsp_pkg::SUM_W'(p_s11[0]) - prsp_pkg::SUM_W'(p_s11[1]);
		ys_s12 <= prsp_pkg::SUM_W'(p_s11[2]) + prsp_pkg::SUM_W'(p_s11[3]);
	end

	// s13: post-scale when not pre-scaled; unscaled sums fit ROT_W bits
	always_ff @(posedge clk) begin
		op_s13 <= op_s12;
		if (op_s12.zoom) begin
			vx_s13 <= prsp_pkg::ACC_W'(xs_s12);
			vy_s13 <= prsp_pkg::ACC_W'(ys_s12);
		end else begin
			vx_s13 <= prsp_pkg::ACC_W'($signed(xs_s12[prsp_pkg::ROT_W-1:0])) *
				prsp_pkg::ACC_W'($signed({1'b0, op_s12.sx}));
			vy_s13 <= prsp_pkg::ACC_W'($signed(ys_s12[prsp_pkg::ROT_W-1:0])) *
				prsp_pkg::ACC_W'($signed({1'b0, op_s12.sy}));
		end
	end

	// s14: floor shift, add pivot back, clamp
	assign rx = prsp_pkg::RES_W'(vx_s13 >>> prsp_pkg::FIX_SHIFT) + prsp_pkg::RES_W'(op_s13.cx);
	assign ry = prsp_pkg::RES_W'(vy_s13 >>> prsp_pkg::FIX_SHIFT) + prsp_pkg::RES_W'(op_s13.cy);

	always_ff @(posedge clk) begin
		out_x_s14 <= prsp_pkg::saturate(rx);
		out_y_s14 <= prsp_pkg::saturate(ry);
	end

endmodule

FILE: src/point_rotate_scale_about_pivot_unit.sv
// Rotate and scale a point about a pivot: 14-stage pipeline, one point per clock.
// done pulses when the beat's results reach the output registers (busy is never high).
// Throughput: one beat per cycle; the stage count is set by the trig path
// (divide by ten, table read, blend, divide by ten) ahead of the rotation multipliers.
// Reset sets the configuration to angle 0, scales 256, pivot 0, zoom_first 0, and drops
// all beats in flight. Results cannot be stalled by the receiver.
module point_rotate_scale_about_pivot_unit (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic signed [prsp_pkg::COORD_W-1:0]  point_x,
	input  logic signed [prsp_pkg::COORD_W-1:0]  point_y,
	output logic                                 done,
	output logic signed [prsp_pkg::COORD_W-1:0]  out_x,
	output logic signed [prsp_pkg::COORD_W-1:0]  out_y,
	input  logic                                 cfg_we,
	input  logic [prsp_pkg::IDX_W-1:0]           cfg_index,
	input  logic [prsp_pkg::CFG_W-1:0]           cfg_wdata
);

	prsp_pkg::cfg_t cfg;

	// Stage 1 registers: the beat plus a snapshot of the configuration it uses
	prsp_pkg::op_t                          op_s1;
	logic signed [prsp_pkg::ANGLE_W-1:0]    lim_s1;
	logic                                   zero_s1;

	// One valid bit per stage; the pipeline never stalls
	logic vld_s [1:prsp_pkg::OUT_STAGE];

	logic signed [prsp_pkg::ANGLE_W:0]      ang_w;
	logic signed [prsp_pkg::ANGLE_W:0]      lim_w;
	logic signed [prsp_pkg::TRIG_W-1:0]     sin_s9, cos_s9;
	logic signed [prsp_pkg::COORD_W-1:0]    out_x_s14, out_y_s14;
	logic                                   accept;

	// Every cycle can take a beat
	assign busy   = 1'b0;
	assign accept = start && !busy;

	prsp_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	// Single wrap of the angle into one turn; leftovers pass through unchanged
	assign ang_w = (prsp_pkg::ANGLE_W + 1)'(cfg.angle_tenths);

	always_comb begin
		priority if (ang_w > (prsp_pkg::ANGLE_W + 1)'(prsp_pkg::FULL_TURN))
			lim_w = ang_w - (prsp_pkg::ANGLE_W + 1)'(prsp_pkg::FULL_TURN);
		else if (ang_w < 0)
			lim_w = ang_w + (prsp_pkg::ANGLE_W + 1)'(prsp_pkg::FULL_TURN);
		else
			lim_w = ang_w;
	end

	// Offsets are taken at full precision (17 bits) so nothing wraps
	always_ff @(posedge clk) begin
		op_s1.ox   <= prsp_pkg::OFF_W'(point_x) - prsp_pkg::OFF_W'(cfg.pivot_x);
		op_s1.oy   <= prsp_pkg::OFF_W'(point_y) - prsp_pkg::OFF_W'(cfg.pivot_y);
		op_s1.cx   <= cfg.pivot_x;
		op_s1.cy   <= cfg.pivot_y;
		op_s1.sx   <= cfg.scale_x;
		op_s1.sy   <= cfg.scale_y;
		op_s1.zoom <= cfg.zoom_first;
		lim_s1     <= lim_w[prsp_pkg::ANGLE_W-1:0];
		zero_s1    <= (cfg.angle_tenths == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 1; i <= prsp_pkg::OUT_STAGE; i++)
				vld_s[i] <= 1'b0;
		end else begin
			vld_s[1] <= accept;
			for (int i = 2; i <= prsp_pkg::OUT_STAGE; i++)
				vld_s[i] <= vld_s[i-1];
		end
	end

	// Stages 2..9: sine and cosine for this beat's angle.
	// Zero angle forces sin 0 and cos exactly 1.0, so identity and
	// scale-only fall out of the same datapath.
	prsp_trig u_trig (
		.clk     (clk),
		.lim_s1  (lim_s1),
		.zero_s1 (zero_s1),
		.sin_s9  (sin_s9),
		.cos_s9  (cos_s9)
	);

	// Stages 10..14: scale, rotate, shift, add pivot, saturate
	prsp_xform u_xform (
		.clk       (clk),
		.op_s1     (op_s1),
		.sin_s9    (sin_s9),
		.cos_s9    (cos_s9),
		.out_x_s14 (out_x_s14),
		.out_y_s14 (out_y_s14)
	);

	assign done  = vld_s[prsp_pkg::OUT_STAGE];
	assign out_x = out_x_s14;
	assign out_y = out_y_s14;

endmodule
